@@ src/spr_pkg.sv @@
`timescale 1ns / 1ps

package spr_pkg;

   // Coordinate width; every datapath width below follows from it.
   localparam int COORD_WIDTH = 16;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH + 1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;

   typedef enum logic [1:0] {
      REL_NONE  = 2'd0,
      REL_CROSS = 2'd1,
      REL_SAME  = 2'd2
   } relation_type;

   // Sign of one orientation cross product.
   typedef struct packed {
      logic neg;
      logic zero;
   } sign_type;

   // Order of A's projections against B's: a=psa, b=pea, c=psb, d=peb.
   typedef struct packed {
      logic lt_ac; logic eq_ac;
      logic lt_ad; logic eq_ad;
      logic lt_bc; logic eq_bc;
      logic lt_bd; logic eq_bd;
   } order_type;

endpackage

@@ src/segment_pair_relation.sv @@
`timescale 1ns / 1ps
// segment_pair_relation: classify two 2D segments as none, crossing or same.
// Pipeline from start to rsp_strobe, one register per stage:
// differences, multipliers, cross/dot sums, projection compares, decision.
// Throughput: one item per cycle; busy is always low, the receiver cannot stall.
// Reset: synchronous, active high; clears the stage valid bits only.
module segment_pair_relation (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  spr_pkg::coord_type     req_a_start_x,
   input  spr_pkg::coord_type     req_a_start_y,
   input  spr_pkg::coord_type     req_a_end_x,
   input  spr_pkg::coord_type     req_a_end_y,
   input  spr_pkg::coord_type     req_b_start_x,
   input  spr_pkg::coord_type     req_b_start_y,
   input  spr_pkg::coord_type     req_b_end_x,
   input  spr_pkg::coord_type     req_b_end_y,
   output logic                   rsp_strobe,
   output logic [1:0]             rsp_relation
);

   // Each stage does fixed work, so the pipe never stalls: accept whenever start.
   assign busy = 1'b0;

   // ---------------------------------------------------------------- stage 1
   // Form the direction vectors and the endpoint offsets used by the
   // orientation tests; keep the raw coordinates for the projections.
   logic                   v1_ff;
   spr_pkg::diff_type      dax_ff, day_ff, dbx_ff, dby_ff;
   spr_pkg::diff_type      ebsa_x_ff, ebsa_y_ff, sbsa_x_ff, sbsa_y_ff;
   spr_pkg::diff_type      easb_x_ff, easb_y_ff, sasb_x_ff, sasb_y_ff;
   spr_pkg::coord_type     c1_ff [8];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      dax_ff    <= spr_pkg::DIFF_WIDTH'(req_a_end_x)   - spr_pkg::DIFF_WIDTH'(req_a_start_x);
      day_ff    <= spr_pkg::DIFF_WIDTH'(req_a_end_y)   - spr_pkg::DIFF_WIDTH'(req_a_start_y);
      dbx_ff    <= spr_pkg::DIFF_WIDTH'(req_b_end_x)   - spr_pkg::DIFF_WIDTH'(req_b_start_x);
      dby_ff    <= spr_pkg::DIFF_WIDTH'(req_b_end_y)   - spr_pkg::DIFF_WIDTH'(req_b_start_y);
      ebsa_x_ff <= spr_pkg::DIFF_WIDTH'(req_b_end_x)   - spr_pkg::DIFF_WIDTH'(req_a_start_x);
      ebsa_y_ff <= spr_pkg::DIFF_WIDTH'(req_b_end_y)   - spr_pkg::DIFF_WIDTH'(req_a_start_y);
      sbsa_x_ff <= spr_pkg::DIFF_WIDTH'(req_b_start_x) - spr_pkg::DIFF_WIDTH'(req_a_start_x);
      sbsa_y_ff <= spr_pkg::DIFF_WIDTH'(req_b_start_y) - spr_pkg::DIFF_WIDTH'(req_a_start_y);
      easb_x_ff <= spr_pkg::DIFF_WIDTH'(req_a_end_x)   - spr_pkg::DIFF_WIDTH'(req_b_start_x);
      easb_y_ff <= spr_pkg::DIFF_WIDTH'(req_a_end_y)   - spr_pkg::DIFF_WIDTH'(req_b_start_y);
      sasb_x_ff <= spr_pkg::DIFF_WIDTH'(req_a_start_x) - spr_pkg::DIFF_WIDTH'(req_b_start_x);
      sasb_y_ff <= spr_pkg::DIFF_WIDTH'(req_a_start_y) - spr_pkg::DIFF_WIDTH'(req_b_start_y);
      c1_ff[0]  <= req_a_start_x;
      c1_ff[1]  <= req_a_start_y;
      c1_ff[2]  <= req_a_end_x;
      c1_ff[3]  <= req_a_end_y;
      c1_ff[4]  <= req_b_start_x;
      c1_ff[5]  <= req_b_start_y;
      c1_ff[6]  <= req_b_end_x;
      c1_ff[7]  <= req_b_end_y;
   end

   // ---------------------------------------------------------------- stage 2
   // All products, one multiplier each: xp = cross terms, dp = dot terms.
   // xp[2k] - xp[2k+1] is cross product k; dp[2k] + dp[2k+1] is projection k.
   logic                   v2_ff;
   spr_pkg::prod_type      xp_ff [8];
   spr_pkg::prod_type      dp_ff [8];

   function automatic spr_pkg::prod_type mul_diff(spr_pkg::diff_type x,
                                                  spr_pkg::diff_type y);
      return spr_pkg::PROD_WIDTH'(x) * spr_pkg::PROD_WIDTH'(y);
   endfunction

   function automatic spr_pkg::prod_type mul_coord(spr_pkg::diff_type x,
                                                   spr_pkg::coord_type y);
      return spr_pkg::PROD_WIDTH'(x) * spr_pkg::PROD_WIDTH'(y);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      // orientation of B's end and start against A's line
      xp_ff[0] <= mul_diff(dax_ff, ebsa_y_ff);
      xp_ff[1] <= mul_diff(day_ff, ebsa_x_ff);
      xp_ff[2] <= mul_diff(dax_ff, sbsa_y_ff);
      xp_ff[3] <= mul_diff(day_ff, sbsa_x_ff);
      // orientation of A's end and start against B's line
      xp_ff[4] <= mul_diff(dbx_ff, easb_y_ff);
      xp_ff[5] <= mul_diff(dby_ff, easb_x_ff);
      xp_ff[6] <= mul_diff(dbx_ff, sasb_y_ff);
      xp_ff[7] <= mul_diff(dby_ff, sasb_x_ff);
      // projections of all four endpoints onto A's direction
      dp_ff[0] <= mul_coord(dax_ff, c1_ff[0]);
      dp_ff[1] <= mul_coord(day_ff, c1_ff[1]);
      dp_ff[2] <= mul_coord(dax_ff, c1_ff[2]);
      dp_ff[3] <= mul_coord(day_ff, c1_ff[3]);
      dp_ff[4] <= mul_coord(dax_ff, c1_ff[4]);
      dp_ff[5] <= mul_coord(day_ff, c1_ff[5]);
      dp_ff[6] <= mul_coord(dax_ff, c1_ff[6]);
      dp_ff[7] <= mul_coord(day_ff, c1_ff[7]);
   end

   // ---------------------------------------------------------------- stage 3
   // Finish the four cross products down to their signs, and the projections.
   logic                   v3_ff;
   spr_pkg::sign_type      sg_ff [4];
   spr_pkg::sum_type       pj_ff [4];
   spr_pkg::sum_type       xs_in [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         xs_in[k] = spr_pkg::SUM_WIDTH'(xp_ff[2*k]) - spr_pkg::SUM_WIDTH'(xp_ff[2*k+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         sg_ff[k].neg  <= xs_in[k][spr_pkg::SUM_WIDTH-1];
         sg_ff[k].zero <= (xs_in[k] == '0);
         pj_ff[k]      <= spr_pkg::SUM_WIDTH'(dp_ff[2*k]) + spr_pkg::SUM_WIDTH'(dp_ff[2*k+1]);
      end
   end

   // ---------------------------------------------------------------- stage 4
   // Order the projections pairwise; settle the general-case tests.
   logic                   v4_ff;
   logic                   colin_ff;
   logic                   cross_ff;
   spr_pkg::order_type     ord_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      colin_ff     <= sg_ff[0].zero && sg_ff[1].zero && sg_ff[2].zero && sg_ff[3].zero;
      // strict sign change on both sides
      cross_ff     <= !sg_ff[0].zero && !sg_ff[1].zero && (sg_ff[0].neg != sg_ff[1].neg) &&
                      !sg_ff[2].zero && !sg_ff[3].zero && (sg_ff[2].neg != sg_ff[3].neg);
      ord_ff.lt_ac <= (pj_ff[0] <  pj_ff[2]);
      ord_ff.eq_ac <= (pj_ff[0] == pj_ff[2]);
      ord_ff.lt_ad <= (pj_ff[0] <  pj_ff[3]);
      ord_ff.eq_ad <= (pj_ff[0] == pj_ff[3]);
      ord_ff.lt_bc <= (pj_ff[1] <  pj_ff[2]);
      ord_ff.eq_bc <= (pj_ff[1] == pj_ff[2]);
      ord_ff.lt_bd <= (pj_ff[1] <  pj_ff[3]);
      ord_ff.eq_bd <= (pj_ff[1] == pj_ff[3]);
   end

   // ---------------------------------------------------------------- stage 5
   // a = A start, b = A end, c = B start, d = B end (projected).
   logic                   gt_ac, gt_ad, gt_bc, gt_bd;
   logic                   same_in, in_a, in_b, in_c, in_d;
   spr_pkg::relation_type  rel_in;
   logic                   v5_ff;
   spr_pkg::relation_type  rel_ff;

   always_comb begin
      gt_ac   = !ord_ff.lt_ac && !ord_ff.eq_ac;
      gt_ad   = !ord_ff.lt_ad && !ord_ff.eq_ad;
      gt_bc   = !ord_ff.lt_bc && !ord_ff.eq_bc;
      gt_bd   = !ord_ff.lt_bd && !ord_ff.eq_bd;
      same_in = (ord_ff.eq_ac && ord_ff.eq_bd) || (ord_ff.eq_ad && ord_ff.eq_bc);
      // strictly inside the other segment's range, either orientation
      in_a    = (gt_ac && ord_ff.lt_ad) || (gt_ad && ord_ff.lt_ac);
      in_b    = (gt_bc && ord_ff.lt_bd) || (gt_bd && ord_ff.lt_bc);
      in_c    = (ord_ff.lt_ac && gt_bc) || (ord_ff.lt_bc && gt_ac);
      in_d    = (ord_ff.lt_ad && gt_bd) || (ord_ff.lt_bd && gt_ad);
      priority if (colin_ff && same_in) begin
         rel_in = spr_pkg::REL_SAME;
      end else if (colin_ff && (in_a || in_b || in_c || in_d)) begin
         rel_in = spr_pkg::REL_CROSS;
      end else if (!colin_ff && cross_ff) begin
         rel_in = spr_pkg::REL_CROSS;
      end else begin
         rel_in = spr_pkg::REL_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      rel_ff <= rel_in;
   end

   // A degenerate pair (both segments single points at one spot) is caught by
   // same_in, so the decision register drives the result directly.
   assign rsp_strobe   = v5_ff;
   assign rsp_relation = rel_ff;

endmodule
